### rtl/core/wtf8u_pkg.sv
// Shared types, constants and helper functions for the WTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps
`default_nettype none

package wtf8u_pkg;

    localparam int UNIT_W   = 16;
    localparam int CP_W     = 21;
    localparam int SLOT_NUM = 3;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SUPP     = 21'h010000;
    localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;
    localparam logic [5:0]      HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]      LO_SURR_TAG = 6'b110111;

    // Sequence class codes (selects overlong minimum).
    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_TWO  = 2'd1;
    localparam logic [1:0] CLS_THREE = 2'd2;
    localparam logic [1:0] CLS_FOUR = 2'd3;

    // Result kind codes.
    localparam logic KIND_UNIT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Register index of the configuration space.
    localparam logic REG_STRICT = 1'b0;

    typedef struct packed {
        logic [UNIT_W-1:0] unit_value;
        logic              result_kind;
        logic              malformed;
    } result_t;

    typedef struct packed {
        logic [1:0]             count;
        result_t [SLOT_NUM-1:0] slot;
    } bundle_t;

    function automatic logic [CP_W-1:0] min_for_class(input logic [1:0] cls);
        logic [CP_W-1:0] m;
        unique case (cls)
            CLS_NONE:  m = 21'h000000;
            CLS_TWO:   m = 21'h000080;
            CLS_THREE: m = 21'h000800;
            CLS_FOUR:  m = 21'h010000;
            default:   m = 21'h000000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/core/wtf8u_decode.sv
// Byte decoder: sequence state registers and per-byte result bundle.
`timescale 1ns / 1ps
`default_nettype none

module wtf8u_decode
    import wtf8u_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        strict_utf8,
    input  wire logic [7:0]  byte_value,
    input  wire logic        last_byte,
    input  wire logic        consume,
    output bundle_t          bundle
);

    logic [CP_W-1:0] acc_reg, acc_next;
    logic [1:0]      rem_reg, rem_next;
    logic [1:0]      cls_reg, cls_next;
    logic            err_reg, err_next;

    logic [CP_W-1:0] acc_shift;
    logic [1:0]      rem_dec;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] cp_off;
    logic            emit;
    logic            bad;
    logic            end_err;
    result_t [SLOT_NUM-1:0] slots;
    logic [1:0]      n;

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cls_next  = cls_reg;
        err_next  = err_reg;
        emit      = 1'b0;
        cp        = {13'd0, byte_value};
        bad       = 1'b0;
        acc_shift = {acc_reg[CP_W-7:0], byte_value[5:0]};
        rem_dec   = rem_reg - 2'd1;

        if (!err_reg)
        begin
            if (rem_reg == 2'd0)
            begin
                priority if (byte_value[7] == 1'b0)
                begin
                    emit = 1'b1;
                end
                else if (byte_value[7:5] == 3'b110)
                begin
                    acc_next = {16'd0, byte_value[4:0]};
                    rem_next = 2'd1;
                    cls_next = CLS_TWO;
                end
                else if (byte_value[7:4] == 4'b1110)
                begin
                    acc_next = {17'd0, byte_value[3:0]};
                    rem_next = 2'd2;
                    cls_next = CLS_THREE;
                end
                else if (byte_value[7:3] == 5'b11110)
                begin
                    acc_next = {18'd0, byte_value[2:0]};
                    rem_next = 2'd3;
                    cls_next = CLS_FOUR;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            else if (byte_value[7:6] != 2'b10)
            begin
                bad = 1'b1;
            end
            else
            begin
                acc_next = acc_shift;
                rem_next = rem_dec;
                if (rem_dec == 2'd0)
                begin
                    cp = acc_shift;
                    if (acc_shift < min_for_class(cls_reg) || acc_shift > CP_MAX)
                        bad = 1'b1;
                    if (strict_utf8 && acc_shift >= CP_SURR_LO && acc_shift <= CP_SURR_HI)
                        bad = 1'b1;
                    if (!bad)
                    begin
                        emit     = 1'b1;
                        acc_next = '0;
                        cls_next = CLS_NONE;
                    end
                end
            end
            if (bad)
            begin
                err_next = 1'b1;
                rem_next = 2'd0;
                acc_next = '0;
                cls_next = CLS_NONE;
            end
        end

        // End of string: cut-short sequence is an error, then start afresh.
        end_err = err_next | (rem_next != 2'd0);
        if (last_byte)
        begin
            acc_next = '0;
            rem_next = 2'd0;
            cls_next = CLS_NONE;
            err_next = 1'b0;
        end
    end

    // Pack units and the end report into consecutive slots.
    always_comb
    begin
        cp_off = cp - CP_SUPP;
        slots  = '0;
        n      = 2'd0;
        if (emit)
        begin
            if (cp >= CP_SUPP)
            begin
                slots[0] = '{unit_value: {HI_SURR_TAG, cp_off[19:10]},
                             result_kind: KIND_UNIT, malformed: 1'b0};
                slots[1] = '{unit_value: {LO_SURR_TAG, cp_off[9:0]},
                             result_kind: KIND_UNIT, malformed: 1'b0};
                n = 2'd2;
            end
            else
            begin
                slots[0] = '{unit_value: cp[UNIT_W-1:0],
                             result_kind: KIND_UNIT, malformed: 1'b0};
                n = 2'd1;
            end
        end
        if (last_byte)
        begin
            slots[n] = '{unit_value: '0, result_kind: KIND_END, malformed: end_err};
            n = n + 2'd1;
        end
        bundle.count = n;
        bundle.slot  = slots;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            rem_reg <= 2'd0;
            cls_reg <= CLS_NONE;
            err_reg <= 1'b0;
        end
        else if (consume)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
            cls_reg <= cls_next;
            err_reg <= err_next;
        end
    end

    // An error always drops any partial sequence.
    assert property (@(posedge clk) disable iff (!rst_n) err_reg |-> (rem_reg == 2'd0))
        else $error("pending continuation bytes while error is set");
    assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == 2'd0) |-> (cls_reg == CLS_NONE))
        else $error("sequence class left over with no sequence open");
    assert property (@(posedge clk) disable iff (!rst_n)
        (consume && last_byte) |=> (rem_reg == 2'd0 && !err_reg && acc_reg == '0))
        else $error("state not cleared after end of string");

endmodule

`default_nettype wire

### rtl/core/wtf8u_serializer.sv
// Result register: holds one bundle and sends its results one beat at a time.
`timescale 1ns / 1ps
`default_nettype none

module wtf8u_serializer
    import wtf8u_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire bundle_t      bundle,
    output logic              load_ok,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [15:0]       m_axis_tdata,  // unit_value[15:0]
    output logic [1:0]        m_axis_tuser,  // [0] result_kind, [1] malformed
    output logic              m_axis_tlast
);

    logic        valid_reg;
    bundle_t     bundle_reg;
    logic [1:0]  idx_reg;
    logic        at_tail;
    result_t     cur;

    assign at_tail = (idx_reg == bundle_reg.count - 2'd1);
    assign load_ok = !valid_reg || (m_axis_tready && at_tail);
    assign cur     = bundle_reg.slot[idx_reg];

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = cur.unit_value;
    assign m_axis_tuser  = {cur.malformed, cur.result_kind};
    assign m_axis_tlast  = at_tail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load_ok)
        begin
            valid_reg <= load;
            idx_reg   <= 2'd0;
        end
        else if (m_axis_tready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && load)
            bundle_reg <= bundle;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (bundle_reg.count != 2'd0 && idx_reg < bundle_reg.count))
        else $error("slot index outside held bundle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && cur.result_kind == KIND_END) |-> at_tail)
        else $error("end report is not the last result of its beat");
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !m_axis_tready) |=> (valid_reg && $stable(idx_reg)))
        else $error("stalled result moved");

endmodule

`default_nettype wire

### rtl/core/wtf8_to_utf16_decoder_unit.sv
// Top level of the WTF-8 to UTF-16 decoder: input register, decoder, result stage, APB.
`timescale 1ns / 1ps
`default_nettype none

// WTF-8 to UTF-16 decoder. Bytes enter on s_axis, one per beat, with tlast on the final
// byte of a string. Each completed code point leaves on m_axis as one UTF-16 unit, or as
// a high then a low surrogate above U+FFFF; the final byte of a string also produces an
// end report (tuser[0]=1) whose tuser[1] flags a malformed string. m_axis tlast marks
// the last result caused by one input byte. After the first error in a string no more
// units come out until its end report. Each byte is held in the input register and is
// decoded in one pass into a bundle of zero to three results; the result register sends
// one result per cycle while m_axis_tready is high, so plain text runs at one byte per
// cycle unless stalled. Register 0 (address 0x0, bit 0) is strict_utf8: when set,
// encoded surrogates U+D800..U+DFFF count as malformed. Write it only while idle.

module wtf8_to_utf16_decoder_unit
    import wtf8u_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // byte input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // byte_value[7:0]
    input  wire logic        s_axis_tlast,   // last_byte
    // result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // unit_value[15:0]
    output logic [1:0]       m_axis_tuser,   // [0] result_kind, [1] malformed
    output logic             m_axis_tlast    // run_last
);

    logic        strict_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        consume;
    logic        load_ok;
    bundle_t     bundle;

    // APB: always ready; one register at index 0, higher index reads zero.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STRICT) ? {31'd0, strict_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strict_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_STRICT)
            strict_reg <= pwdata[0];
    end

    // Byte leaves the input register when its bundle is empty or the result stage frees.
    assign consume       = in_valid_reg && (bundle.count == 2'd0 || load_ok);
    assign s_axis_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    wtf8u_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .strict_utf8 (strict_reg),
        .byte_value  (in_byte_reg),
        .last_byte   (in_last_reg),
        .consume     (consume),
        .bundle      (bundle)
    );

    wtf8u_serializer u_serializer (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (consume && bundle.count != 2'd0),
        .bundle        (bundle),
        .load_ok       (load_ok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### verif/wtf8_to_utf16_decoder_unit_test.sv
// Self-checking testbench for the WTF-8 to UTF-16 decoder unit.
`timescale 1ns / 1ps

module wtf8_to_utf16_decoder_unit_test;
    import wtf8u_pkg::*;

    localparam int          CLK_PERIOD   = 12;
    localparam int          RESET_CYCLES = 5;
    // Input register plus result register, with margin for a byte that makes no beat.
    localparam int          DRAIN_CYCLES = 8;
    // Slowest legal run is roughly 310 bytes * 3 beats * a full stall period plus gaps.
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          STALL_PERIOD = 13;
    localparam int          RANDOM_PHASES = 4;
    localparam int          PHASE_BYTES  = 66;
    localparam logic [2:0]  STRICT_ADDR  = {REG_STRICT, 2'b00};

    // One input beat: raw byte plus end-of-string flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } wtf8_byte_t;

    // One output beat as the decoder should produce it.
    typedef struct packed {
        logic [15:0] unit;
        logic        kind;
        logic        bad;
        logic        run_last;
    } utf16_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // byte_value[7:0]
    logic        s_axis_tlast = 1'b0; // last_byte

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // unit_value[15:0]
    logic [1:0]  m_axis_tuser;        // [0] result_kind, [1] malformed
    logic        m_axis_tlast;        // run_last

    wtf8_to_utf16_decoder_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Bytes waiting to go out, and code units / end reports still owed by the DUT.
    wtf8_byte_t  pending_bytes[$];
    utf16_beat_t expected_beats[$];

    // Shadow decoder state, advanced on every accepted byte.
    logic        strict_mode = 1'b0;
    logic [20:0] dec_acc = '0;
    logic [1:0]  dec_remaining = '0;
    logic [1:0]  dec_class = CLS_NONE;
    logic        dec_error = 1'b0;

    // Traffic shaping, retuned per phase by the stimulus block.
    int                       gap_max = 0;
    logic [STALL_PERIOD-1:0]  ready_pattern = '1;
    int                       gap_left = 0;
    int                       burst_left = 1;
    int                       stall_phase = 0;

    int          error_count = 0;
    int          cycle_count = 0;
    int          bytes_queued = 0;
    int          bytes_accepted = 0;
    int          units_seen = 0;
    int          ends_seen = 0;
    int          malformed_seen = 0;
    int          strict_writes = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    function automatic utf16_beat_t make_beat(input logic [15:0] unit, input logic kind,
                                              input logic bad);
        utf16_beat_t b;
        b.unit     = unit;
        b.kind     = kind;
        b.bad      = bad;
        b.run_last = 1'b0;
        return b;
    endfunction

    // Any decode error: drop the partial sequence and mute the rest of the string.
    function automatic void flag_decode_error();
        dec_error     = 1'b1;
        dec_remaining = 2'd0;
        dec_acc       = '0;
        dec_class     = CLS_NONE;
    endfunction

    // Shadow decoder: one accepted byte in, zero to three expected beats queued.
    function automatic void decode_byte(input logic [7:0] b, input logic ends);
        utf16_beat_t produced[3];
        int          k;
        logic [20:0] cp;
        logic [20:0] floor;
        logic [20:0] offs;
        logic        bad;
        k = 0;
        if (!dec_error)
        begin
            if (dec_remaining == 2'd0)
            begin
                if (b[7] == 1'b0)
                begin
                    produced[k] = make_beat({8'h00, b}, KIND_UNIT, 1'b0);
                    k++;
                end
                else if (b[7:5] == 3'b110)
                begin
                    dec_acc       = {16'h0, b[4:0]};
                    dec_remaining = 2'd1;
                    dec_class     = CLS_TWO;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    dec_acc       = {17'h0, b[3:0]};
                    dec_remaining = 2'd2;
                    dec_class     = CLS_THREE;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    dec_acc       = {18'h0, b[2:0]};
                    dec_remaining = 2'd3;
                    dec_class     = CLS_FOUR;
                end
                else
                begin
                    flag_decode_error();
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                flag_decode_error();
            end
            else
            begin
                dec_acc       = {dec_acc[14:0], b[5:0]};
                dec_remaining = dec_remaining - 2'd1;
                if (dec_remaining == 2'd0)
                begin
                    cp = dec_acc;
                    case (dec_class)
                        CLS_TWO:   floor = 21'h000080;
                        CLS_THREE: floor = 21'h000800;
                        CLS_FOUR:  floor = 21'h010000;
                        default:   floor = 21'h000000;
                    endcase
                    bad = (cp < floor) || (cp > CP_MAX);
                    // strict mode is judged when the code point completes
                    if (strict_mode && cp >= CP_SURR_LO && cp <= CP_SURR_HI)
                        bad = 1'b1;
                    if (bad)
                    begin
                        flag_decode_error();
                    end
                    else
                    begin
                        if (cp <= 21'h00FFFF)
                        begin
                            produced[k] = make_beat(cp[15:0], KIND_UNIT, 1'b0);
                            k++;
                        end
                        else
                        begin
                            offs = cp - CP_SUPP;
                            produced[k] = make_beat(16'hD800 + {6'h0, offs[19:10]},
                                                    KIND_UNIT, 1'b0);
                            k++;
                            produced[k] = make_beat(16'hDC00 + {6'h0, offs[9:0]},
                                                    KIND_UNIT, 1'b0);
                            k++;
                        end
                        dec_acc   = '0;
                        dec_class = CLS_NONE;
                    end
                end
            end
        end

        if (ends)
        begin
            // string cut short inside a multi-byte sequence
            if (!dec_error && dec_remaining != 2'd0)
                flag_decode_error();
            produced[k] = make_beat(16'h0000, KIND_END, dec_error);
            k++;
            dec_acc       = '0;
            dec_remaining = 2'd0;
            dec_class     = CLS_NONE;
            dec_error     = 1'b0;
        end

        if (k > 0)
            produced[k-1].run_last = 1'b1;
        for (int i = 0; i < k; i++)
            expected_beats.push_back(produced[i]);
    endfunction

    // Sender: bursts of back-to-back beats separated by random gaps. A beat
    // that is offered stays put until the DUT takes it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(s_axis_tdata, s_axis_tlast);
                void'(pending_bytes.pop_front());
                bytes_accepted++;
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_bytes[0].data;
                    s_axis_tlast  <= pending_bytes[0].last;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: tready follows a rotating stall pattern; every accepted beat
    // is checked against the oldest expected beat.
    always @(posedge clk)
    begin
        utf16_beat_t want;
        if (rst_n)
        begin
            m_axis_tready <= ready_pattern[stall_phase];
            stall_phase = (stall_phase + 1) % STALL_PERIOD;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    report_mismatch("unexpected beat, unit", m_axis_tdata, 0);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (m_axis_tdata != want.unit)
                        report_mismatch("unit_value", m_axis_tdata, want.unit);
                    if (m_axis_tuser[0] != want.kind)
                        report_mismatch("result_kind", m_axis_tuser[0], want.kind);
                    if (m_axis_tuser[1] != want.bad)
                        report_mismatch("malformed", m_axis_tuser[1], want.bad);
                    if (m_axis_tlast != want.run_last)
                        report_mismatch("run_last", m_axis_tlast, want.run_last);
                end
                if (m_axis_tuser[0] == KIND_END)
                begin
                    ends_seen++;
                    if (m_axis_tuser[1])
                        malformed_seen++;
                end
                else
                begin
                    units_seen++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d beats still expected",
                     cycle_count, expected_beats.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void queue_byte(input logic [7:0] data, input logic ends);
        wtf8_byte_t item;
        item.data = data;
        item.last = ends;
        pending_bytes.push_back(item);
        bytes_queued++;
    endfunction

    // Directed strings, written most significant byte first.
    task automatic queue_packed(input logic [63:0] bytes, input int count, input logic ends);
        for (int i = count - 1; i >= 0; i--)
            queue_byte(bytes[i*8 +: 8], ends && (i == 0));
    endtask

    // Random code point of the given sequence length, biased toward the class edges
    // and, for three-byte forms, the surrogate block.
    function automatic logic [20:0] pick_point(input int cls);
        logic [20:0] lo;
        logic [20:0] hi;
        int          roll;
        case (cls)
            0:       begin lo = 21'h000000; hi = 21'h00007F; end
            1:       begin lo = 21'h000080; hi = 21'h0007FF; end
            2:       begin lo = 21'h000800; hi = 21'h00FFFF; end
            default: begin lo = 21'h010000; hi = 21'h10FFFF; end
        endcase
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return lo;
        if (roll == 1)
            return hi;
        if (roll < 4 && cls == 2)
            return 21'($urandom_range(32'hD800, 32'hDFFF));
        return 21'($urandom_range(32'(lo), 32'(hi)));
    endfunction

    // One random string: mostly well-formed code points, with some noise bytes,
    // overlong and out-of-range forms, corrupted and truncated sequences.
    task automatic queue_random_string();
        logic [7:0]  seq[$];
        logic [7:0]  enc[$];
        logic [20:0] cp;
        int          points;
        int          roll;
        int          cls;
        int          cut;
        points = $urandom_range(1, 5);
        for (int i = 0; i < points; i++)
        begin
            roll = $urandom_range(0, 99);
            enc.delete();
            if (roll < 8)
            begin
                enc.push_back(8'($urandom));
            end
            else
            begin
                cls = $urandom_range(0, 3);
                cp  = pick_point(cls);
                if (roll < 14)
                begin
                    // value that fits a shorter form: overlong
                    cls = $urandom_range(1, 3);
                    cp  = pick_point(cls - 1);
                end
                else if (roll < 18)
                begin
                    cls = 3;
                    cp  = 21'($urandom_range(32'h110000, 32'h1FFFFF));
                end
                case (cls)
                    0:
                    begin
                        enc.push_back({1'b0, cp[6:0]});
                    end
                    1:
                    begin
                        enc.push_back({3'b110, cp[10:6]});
                        enc.push_back({2'b10, cp[5:0]});
                    end
                    2:
                    begin
                        enc.push_back({4'b1110, cp[15:12]});
                        enc.push_back({2'b10, cp[11:6]});
                        enc.push_back({2'b10, cp[5:0]});
                    end
                    default:
                    begin
                        enc.push_back({5'b11110, cp[20:18]});
                        enc.push_back({2'b10, cp[17:12]});
                        enc.push_back({2'b10, cp[11:6]});
                        enc.push_back({2'b10, cp[5:0]});
                    end
                endcase
                if (roll >= 18 && roll < 24 && enc.size() > 1)
                begin
                    enc[$urandom_range(1, enc.size() - 1)] = 8'($urandom);
                end
                else if (roll >= 24 && roll < 28 && enc.size() > 1)
                begin
                    cut = $urandom_range(1, enc.size() - 1);
                    repeat (cut) void'(enc.pop_back());
                end
            end
            foreach (enc[j])
                seq.push_back(enc[j]);
        end
        foreach (seq[j])
            queue_byte(seq[j], j == seq.size() - 1);
    endtask

    // Idle means: nothing left to send, nothing owed, and a few quiet cycles so
    // that a byte which makes no beat has cleared the pipeline too.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_beats.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // APB write of strict_utf8 followed by a read-back, only while idle.
    task automatic write_strict(input logic value);
        wait_idle();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= STRICT_ADDR;
        pwdata  <= {31'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        strict_mode = value;
        strict_writes++;
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[0] != value)
            report_mismatch("strict_utf8 read-back", prdata[0], value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Stimulus: directed strings, then random phases with varied strict mode and traffic.
    initial
    begin
        int   target;
        logic strict_pick;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, strict mode at its reset value (off).
        gap_max       = 3;
        ready_pattern = 13'($urandom) | 13'h1;
        // ASCII minimum, top of the two- and three-byte ranges ...
        queue_packed(64'h00DFBFEFBFBF, 6, 1'b0);
        // ... and U+10FFFF as the string's last byte: pair plus end report
        queue_packed(64'hF48FBFBF, 4, 1'b1);
        queue_packed(64'h7F, 1, 1'b1);
        // overlong two-byte form; the byte after the error is ignored
        queue_packed(64'hC08041, 3, 1'b1);
        // above U+10FFFF
        queue_packed(64'hF4908080, 4, 1'b1);
        // string ends inside a sequence
        queue_packed(64'hE282, 2, 1'b1);
        // encoded surrogate, accepted while strict is off
        queue_packed(64'hEDA080, 3, 1'b1);
        // bad lead byte, then bad continuation byte
        queue_packed(64'hFF, 1, 1'b1);
        queue_packed(64'hC241, 2, 1'b1);

        write_strict(1'b1);
        queue_packed(64'hEDBFBF, 3, 1'b1);
        // strict switched off mid-string: the setting at completion wins
        queue_packed(64'hEDA0, 2, 1'b0);
        write_strict(1'b0);
        queue_packed(64'h80, 1, 1'b1);

        // Random phases: the first runs with no idling on either side.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       strict_pick = 1'b1;
                1:       strict_pick = 1'b0;
                default: strict_pick = 1'($urandom_range(0, 1));
            endcase
            write_strict(strict_pick);
            gap_max       = (p == 0) ? 0 : 2 * p;
            ready_pattern = (p == 0) ? '1 : (13'($urandom) | 13'h1);
            target = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target)
                queue_random_string();
        end

        wait_idle();
        $display("Decoded %0d bytes into %0d code units and %0d string ends (%0d malformed)",
                 bytes_accepted, units_seen, ends_seen, malformed_seen);
        $display("Strict mode written %0d times, with sender gaps and receiver stalls varied",
                 strict_writes);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
